// File: rtl/core/dmy_text_to_day_number_core_assert.svh
// Assertion macros shared by the date conversion core.
// Needs no package; each user supplies its own clock and reset.
`ifndef DMY_TEXT_TO_DAY_NUMBER_CORE_ASSERT_SVH
`define DMY_TEXT_TO_DAY_NUMBER_CORE_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define DMYD_ASSERT_NOW(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Condition implies consequence in the next cycle.
`define DMYD_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/dmyd_pkg.sv
// Package for the date text to day number core: parsed field struct,
// month start table and fixed constants. No dependencies.
`default_nettype none

package dmyd_pkg;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharOne  = 8'h31;
  localparam logic [7:0] MinTextLength = 8'd10;
  localparam logic [4:0] MonthsPerYear = 5'd12;
  localparam logic [4:0] February = 5'd2;
  localparam logic [8:0] DaysPerYear = 9'd365;
  localparam logic [23:0] EpochOffset = 24'd719529;

  typedef struct packed {
    logic       bad;
    logic [4:0] month;
    logic [6:0] mday;
    logic [6:0] century;
    logic [6:0] year_low;
  } dmyd_fields_t;

  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] v;
    unique case (idx)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd59;
      4'd3:    v = 9'd90;
      4'd4:    v = 9'd120;
      4'd5:    v = 9'd151;
      4'd6:    v = 9'd181;
      4'd7:    v = 9'd212;
      4'd8:    v = 9'd243;
      4'd9:    v = 9'd273;
      4'd10:   v = 9'd304;
      4'd11:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CharZero) && (ch <= CharNine);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/dmyd_parse.sv
// Character checks and decimal field extraction for one date string.
// Uses dmyd_pkg for the field struct and character constants.
`default_nettype none

module dmyd_parse (
  input  wire logic [7:0]          day_tens_char_i,
  input  wire logic [7:0]          day_ones_char_i,
  input  wire logic [7:0]          month_tens_char_i,
  input  wire logic [7:0]          month_ones_char_i,
  input  wire logic [7:0]          year_thousands_char_i,
  input  wire logic [7:0]          year_hundreds_char_i,
  input  wire logic [7:0]          year_tens_char_i,
  input  wire logic [7:0]          year_ones_char_i,
  input  wire logic [7:0]          text_length_i,
  output dmyd_pkg::dmyd_fields_t   fields_o
);

  logic       all_digits;
  logic [4:0] month;

  assign all_digits = dmyd_pkg::is_digit(day_tens_char_i)
                   && dmyd_pkg::is_digit(day_ones_char_i)
                   && dmyd_pkg::is_digit(month_tens_char_i)
                   && dmyd_pkg::is_digit(month_ones_char_i)
                   && dmyd_pkg::is_digit(year_thousands_char_i)
                   && dmyd_pkg::is_digit(year_hundreds_char_i)
                   && dmyd_pkg::is_digit(year_tens_char_i)
                   && dmyd_pkg::is_digit(year_ones_char_i);

  assign month = ((month_tens_char_i == dmyd_pkg::CharOne) ? 5'd10 : 5'd0)
               + {1'b0, month_ones_char_i[3:0]};

  assign fields_o.month    = month;
  assign fields_o.mday     = 7'({3'b000, day_tens_char_i[3:0]} * 7'd10)
                           + {3'b000, day_ones_char_i[3:0]};
  assign fields_o.century  = 7'({3'b000, year_thousands_char_i[3:0]} * 7'd10)
                           + {3'b000, year_hundreds_char_i[3:0]};
  assign fields_o.year_low = 7'({3'b000, year_tens_char_i[3:0]} * 7'd10)
                           + {3'b000, year_ones_char_i[3:0]};
  assign fields_o.bad      = !all_digits
                          || (text_length_i < dmyd_pkg::MinTextLength)
                          || (month == 5'd0)
                          || (month > dmyd_pkg::MonthsPerYear);

endmodule

`default_nettype wire

// File: rtl/core/dmyd_days.sv
// Closed-form Gregorian day count from parsed date fields.
// Uses dmyd_pkg for the field struct, month start table and epoch offset.
`default_nettype none

module dmyd_days (
  input  wire dmyd_pkg::dmyd_fields_t fields_i,
  output logic [22:0]                 days_o
);

  logic        yy_nz;
  logic        leap;
  logic        cent_round;
  logic [13:0] year;
  logic [4:0]  q4;
  logic [11:0] leaps;
  logic [8:0]  yday;
  logic [3:0]  month_idx;
  logic [23:0] sum;

  assign yy_nz      = (fields_i.year_low != 7'd0);
  assign leap       = yy_nz ? (fields_i.year_low[1:0] == 2'b00)
                            : (fields_i.century[1:0] == 2'b00);
  assign cent_round = (fields_i.century[1:0] != 2'b00) || yy_nz;
  assign year       = 14'(14'(fields_i.century) * 14'd100) + 14'(fields_i.year_low);
  assign q4         = 5'((8'(fields_i.year_low) + 8'd3) >> 2);
  assign leaps      = 12'(12'(fields_i.century) * 12'd24) + 12'(q4)
                    + 12'(fields_i.century[6:2]) + 12'(cent_round) - 12'(yy_nz);
  assign month_idx  = 4'(fields_i.month - 5'd1);
  assign yday       = dmyd_pkg::month_start(month_idx) + 9'(fields_i.mday)
                    + 9'(leap && (fields_i.month > dmyd_pkg::February));
  assign sum        = 24'(24'(year) * 24'(dmyd_pkg::DaysPerYear)) + 24'(leaps)
                    + 24'(yday) - dmyd_pkg::EpochOffset;
  assign days_o     = sum[22:0];

endmodule

`default_nettype wire

// File: rtl/core/dmy_text_to_day_number_core.sv
// Top level of the date text to day number core: input register, parse and
// day count logic, result register. Uses dmyd_pkg, dmyd_parse, dmyd_days.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------
//   input   | in        | in_valid_i / in_stall_o    | eight chars, text_length_i
//   output  | out       | out_valid_o / out_stall_i  | day_number_o, invalid_o
//
// An input register and then a result register lie between an input transaction
// and its result. One transaction per cycle is sustained while out_stall_i is
// low; the rate is set by the single pass through the parse and day count logic.
// Reset clears both stage valid flags only. A stall on the output holds the
// result register and, once the input register is also full, raises in_stall_o.
`default_nettype none
`include "dmy_text_to_day_number_core_assert.svh"

module dmy_text_to_day_number_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         day_tens_char_i,
  input  wire logic [7:0]         day_ones_char_i,
  input  wire logic [7:0]         month_tens_char_i,
  input  wire logic [7:0]         month_ones_char_i,
  input  wire logic [7:0]         year_thousands_char_i,
  input  wire logic [7:0]         year_hundreds_char_i,
  input  wire logic [7:0]         year_tens_char_i,
  input  wire logic [7:0]         year_ones_char_i,
  input  wire logic [7:0]         text_length_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [22:0]      day_number_o,
  output logic                    invalid_o
);

  logic        in_v_q;
  logic        out_v_q;
  logic        adv_out;
  logic        adv_in;
  logic [7:0]  dt_q, do_q, mt_q, mo_q, yth_q, yh_q, yt_q, yo_q, len_q;
  logic [22:0] days;
  logic signed [22:0] day_number_q;
  logic        invalid_q;

  dmyd_pkg::dmyd_fields_t fields;

  assign adv_out    = !out_v_q || !out_stall_i;
  assign adv_in     = !in_v_q || adv_out;
  assign in_stall_o = !adv_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv_in) begin
        in_v_q <= in_valid_i;
      end
      if (adv_out) begin
        out_v_q <= in_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      dt_q  <= day_tens_char_i;
      do_q  <= day_ones_char_i;
      mt_q  <= month_tens_char_i;
      mo_q  <= month_ones_char_i;
      yth_q <= year_thousands_char_i;
      yh_q  <= year_hundreds_char_i;
      yt_q  <= year_tens_char_i;
      yo_q  <= year_ones_char_i;
      len_q <= text_length_i;
    end
    if (adv_out && in_v_q) begin
      invalid_q    <= fields.bad;
      day_number_q <= fields.bad ? 23'sd0 : $signed(days);
    end
  end

  dmyd_parse u_parse (
    .day_tens_char_i       (dt_q),
    .day_ones_char_i       (do_q),
    .month_tens_char_i     (mt_q),
    .month_ones_char_i     (mo_q),
    .year_thousands_char_i (yth_q),
    .year_hundreds_char_i  (yh_q),
    .year_tens_char_i      (yt_q),
    .year_ones_char_i      (yo_q),
    .text_length_i         (len_q),
    .fields_o              (fields)
  );

  dmyd_days u_days (
    .fields_i (fields),
    .days_o   (days)
  );

  assign out_valid_o  = out_v_q;
  assign day_number_o = day_number_q;
  assign invalid_o    = invalid_q;

  `DMYD_ASSERT_NOW(a_invalid_zero, clk_i, rst_ni, out_v_q && invalid_q,
                   day_number_q == 23'sd0)
  `DMYD_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o,
                   in_v_q && out_v_q && out_stall_i)
  `DMYD_ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, in_valid_i && !in_stall_o, in_v_q)
  `DMYD_ASSERT_NEXT(a_stage_moves, clk_i, rst_ni, in_v_q && adv_out, out_v_q)

endmodule

`default_nettype wire

// File: tb/dmy_text_to_day_number_core_tb.sv
// Self-checking testbench for dmy_text_to_day_number_core: directed dates, then
// random date strings under varying valid/stall pressure, against a local model.
// Depends on dmyd_pkg for character and calendar constants.
`timescale 1ns / 1ps

module dmy_text_to_day_number_core_tb;

  localparam int unsigned DaysBeforeMonth [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };
  localparam int unsigned ItemsPerPhase = 350;
  localparam int unsigned HoldOffCycles = 150;
  localparam int unsigned QuietLimit    = 3000;
  localparam int unsigned ReportLimit   = 10;

  typedef struct packed {
    logic [7:0] day_tens;
    logic [7:0] day_ones;
    logic [7:0] month_tens;
    logic [7:0] month_ones;
    logic [7:0] year_thousands;
    logic [7:0] year_hundreds;
    logic [7:0] year_tens;
    logic [7:0] year_ones;
    logic [7:0] text_length;
  } date_text_t;

  typedef struct {
    logic signed [22:0] day_number;
    logic               invalid;
  } day_result_t;

  typedef struct {
    date_text_t  text;
    bit          typed;
    day_result_t want;
  } date_case_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         day_tens_char_i = '0;
  logic [7:0]         day_ones_char_i = '0;
  logic [7:0]         month_tens_char_i = '0;
  logic [7:0]         month_ones_char_i = '0;
  logic [7:0]         year_thousands_char_i = '0;
  logic [7:0]         year_hundreds_char_i = '0;
  logic [7:0]         year_tens_char_i = '0;
  logic [7:0]         year_ones_char_i = '0;
  logic [7:0]         text_length_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [22:0] day_number_o;
  logic               invalid_o;

  day_result_t pending_days [$];
  bit          offer_typed = 1'b0;
  day_result_t offer_want;
  int unsigned fault_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  dmy_text_to_day_number_core DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned digit_value(input logic [7:0] ch);
    return int'(ch) - int'(dmyd_pkg::CharZero);
  endfunction

  function automatic logic [7:0] digit_char(input int unsigned v);
    return 8'(int'(dmyd_pkg::CharZero) + v);
  endfunction

  function automatic day_result_t civil_day_number(input date_text_t d);
    logic [7:0]  chars [8];
    day_result_t r;
    int unsigned mday, mon, yr, yday, leaps;
    bit          leap;
    r.day_number = '0;
    r.invalid = 1'b1;
    chars = '{d.day_tens, d.day_ones, d.month_tens, d.month_ones,
              d.year_thousands, d.year_hundreds, d.year_tens, d.year_ones};
    if (d.text_length < dmyd_pkg::MinTextLength) return r;
    foreach (chars[i]) begin
      if (chars[i] < dmyd_pkg::CharZero || chars[i] > dmyd_pkg::CharNine) return r;
    end
    mday = 10 * digit_value(d.day_tens) + digit_value(d.day_ones);
    mon  = (d.month_tens == dmyd_pkg::CharOne ? 10 : 0) + digit_value(d.month_ones);
    yr   = 1000 * digit_value(d.year_thousands) + 100 * digit_value(d.year_hundreds)
         + 10 * digit_value(d.year_tens) + digit_value(d.year_ones);
    if (mon < 1 || mon > dmyd_pkg::MonthsPerYear) return r;
    leap  = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    leaps = (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400;
    yday  = DaysBeforeMonth[mon - 1] + mday
          + ((leap && mon > dmyd_pkg::February) ? 1 : 0);
    r.day_number = 23'(int'(yr * dmyd_pkg::DaysPerYear + leaps + yday)
                       - int'(dmyd_pkg::EpochOffset));
    r.invalid = 1'b0;
    return r;
  endfunction

  function automatic date_case_t dated(input string s, input logic [7:0] len,
                                       input bit typed, input int want_day,
                                       input bit want_bad);
    date_case_t c;
    c.text = '{s[0], s[1], s[3], s[4], s[6], s[7], s[8], s[9], len};
    c.typed = typed;
    c.want.day_number = want_day[22:0];
    c.want.invalid = want_bad;
    return c;
  endfunction

  function automatic date_text_t random_date();
    date_text_t  d;
    int unsigned pick, yr, mon, mday;
    pick = $urandom_range(99);
    mday = (pick < 50) ? $urandom_range(31, 1) : $urandom_range(99);
    mon  = $urandom_range(12, 1);
    yr   = (pick % 4 == 0) ? $urandom_range(9999) : $urandom_range(2110, 1890);
    d.day_tens       = digit_char(mday / 10);
    d.day_ones       = digit_char(mday % 10);
    d.month_tens     = digit_char(mon / 10);
    d.month_ones     = digit_char(mon % 10);
    d.year_thousands = digit_char(yr / 1000);
    d.year_hundreds  = digit_char((yr / 100) % 10);
    d.year_tens      = digit_char((yr / 10) % 10);
    d.year_ones      = digit_char(yr % 10);
    d.text_length    = (pick % 3 == 0) ? 8'($urandom_range(255, 11))
                                       : dmyd_pkg::MinTextLength;
    if (pick >= 80 && pick < 88) begin
      d.month_tens = digit_char($urandom_range(9, 2));
      d.month_ones = digit_char($urandom_range(9));
    end else if (pick >= 88) begin
      case ($urandom_range(9))
        0: d.day_tens       = 8'($urandom_range(255));
        1: d.day_ones       = 8'($urandom_range(255));
        2: d.month_tens     = 8'($urandom_range(255));
        3: d.month_ones     = 8'($urandom_range(255));
        4: d.year_thousands = 8'($urandom_range(255));
        5: d.year_hundreds  = 8'($urandom_range(255));
        6: d.year_tens      = 8'($urandom_range(255));
        7: d.year_ones      = 8'($urandom_range(255));
        8: d.text_length    = 8'($urandom_range(255));
        default: begin
          d.month_tens = ($urandom_range(1) == 0) ? dmyd_pkg::CharZero : dmyd_pkg::CharOne;
          d.month_ones = (d.month_tens == dmyd_pkg::CharOne) ? digit_char($urandom_range(9, 3))
                                                             : dmyd_pkg::CharZero;
        end
      endcase
    end
    return d;
  endfunction

  task automatic offer_date(input date_text_t d, input bit typed, input day_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    day_tens_char_i       = d.day_tens;
    day_ones_char_i       = d.day_ones;
    month_tens_char_i     = d.month_tens;
    month_ones_char_i     = d.month_ones;
    year_thousands_char_i = d.year_thousands;
    year_hundreds_char_i  = d.year_hundreds;
    year_tens_char_i      = d.year_tens;
    year_ones_char_i      = d.year_ones;
    text_length_i         = d.text_length;
    offer_typed           = typed;
    offer_want            = want;
    in_valid_i            = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HoldOffCycles;
    end
    if (hold_left != 0) begin
      out_stall_i = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    day_result_t want;
    date_text_t  seen;
    bit          quiet;
    if (rst_ni) begin
      quiet = 1'b1;
      if (in_valid_i && !in_stall_o) begin
        seen = '{day_tens_char_i, day_ones_char_i, month_tens_char_i, month_ones_char_i,
                 year_thousands_char_i, year_hundreds_char_i, year_tens_char_i,
                 year_ones_char_i, text_length_i};
        pending_days.push_back(offer_typed ? offer_want : civil_day_number(seen));
        quiet = 1'b0;
      end
      if (out_valid_o && !out_stall_i) begin
        quiet = 1'b0;
        if (pending_days.size() == 0) begin
          fault_count++;
          if (fault_count <= ReportLimit)
            $display("unexpected transaction: day %0d invalid %0b", day_number_o, invalid_o);
        end else begin
          want = pending_days.pop_front();
          if (day_number_o !== want.day_number || invalid_o !== want.invalid) begin
            fault_count++;
            if (fault_count <= ReportLimit)
              $display("mismatch: expected day %0d invalid %0b, got day %0d invalid %0b",
                       want.day_number, want.invalid, day_number_o, invalid_o);
          end
        end
      end
      quiet_cycles = quiet ? quiet_cycles + 1 : 0;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    date_case_t  cases [$];
    date_case_t  c;
    day_result_t none;
    none.day_number = '0;
    none.invalid = 1'b0;
    cases.push_back(dated("01/01/1970", 10, 1, 0, 0));
    cases.push_back(dated("00/01/1970", 10, 1, -1, 0));
    cases.push_back(dated("00/01/0000", 10, 1, -719529, 0));
    cases.push_back(dated("99/12/9999", 10, 1, 2932964, 0));
    cases.push_back(dated("01/01/1970", 9, 1, 0, 1));
    cases.push_back(dated("01/01/1970", 0, 1, 0, 1));
    cases.push_back(dated("01/01/1970", 255, 1, 0, 0));
    cases.push_back(dated("01.01-1970", 10, 1, 0, 0));
    cases.push_back(dated("15/00/2000", 10, 1, 0, 1));
    cases.push_back(dated("15/13/2000", 10, 1, 0, 1));
    cases.push_back(dated("15/19/2000", 10, 1, 0, 1));
    cases.push_back(dated("15/23/2000", 10, 0, 0, 0));
    cases.push_back(dated("15/99/2000", 10, 0, 0, 0));
    cases.push_back(dated("29/02/2000", 10, 0, 0, 0));
    cases.push_back(dated("01/03/2000", 10, 0, 0, 0));
    cases.push_back(dated("01/03/1900", 10, 0, 0, 0));
    cases.push_back(dated("01/03/0000", 10, 0, 0, 0));
    cases.push_back(dated("01/03/2024", 10, 0, 0, 0));
    cases.push_back(dated("31/12/1999", 11, 0, 0, 0));
    cases.push_back(dated("01/01/2021", 10, 0, 0, 0));
    cases.push_back(dated("/1/01/1970", 10, 1, 0, 1));
    cases.push_back(dated("01/01/197:", 10, 1, 0, 1));
    cases.push_back(dated("01/a1/1970", 10, 1, 0, 1));
    c = dated("01/01/1970", 10, 1, 0, 1);
    c.text.day_ones = 8'h00;
    cases.push_back(c);
    c.text.day_ones = dmyd_pkg::CharZero;
    c.text.year_hundreds = 8'hFF;
    cases.push_back(c);

    @(posedge rst_ni);
    @(negedge clk_i);
    foreach (cases[k]) offer_date(cases[k].text, cases[k].typed, cases[k].want);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = (p == 1 || p == 3) ? ((p == 1) ? 47 : 6) : 0;
      stall_pct     = (p == 2 || p == 3) ? ((p == 2) ? 47 : 6) : 0;
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        if (n == 100 && (p == 0 || p == 3)) hold_requests++;
        if (n == 200 && p == 1) begin
          // hold off until every pending result has drained
          in_valid_i = 1'b0;
          do @(negedge clk_i); while (pending_days.size() != 0);
        end
        offer_date(random_date(), 1'b0, none);
      end
    end
    in_valid_i = 1'b0;

    while (pending_days.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
